[rtl/pidtf_pkg.sv]
// Shared types and constants for the PID heater controller with triac phase firing.
// Holds opcodes, register indexes, reset values, fixed-point constants and stage words.
// No dependencies.
package pidtf_pkg;

   localparam logic [1:0] OP_SAMPLE     = 2'd0;
   localparam logic [1:0] OP_ZERO_CROSS = 2'd1;
   localparam logic [1:0] OP_TICK       = 2'd2;

   localparam logic [2:0] REG_SETPOINT  = 3'd0;
   localparam logic [2:0] REG_GAIN_P    = 3'd1;
   localparam logic [2:0] REG_GAIN_I    = 3'd2;
   localparam logic [2:0] REG_GAIN_D    = 3'd3;
   localparam logic [2:0] REG_INT_LIMIT = 3'd4;

   localparam logic [8:0] SETPOINT_RST  = 9'd37;
   localparam logic [9:0] GAIN_P_RST    = 10'd303;
   localparam logic [7:0] GAIN_I_RST    = 8'd7;
   localparam logic [7:0] GAIN_D_RST    = 8'd1;
   localparam logic [8:0] INT_LIMIT_RST = 9'd30;

   localparam logic [10:0] ADC_FULL_SCALE = 11'd1023;

   localparam logic signed [31:0] INTEGRAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INTEGRAL_MIN = 32'sh8000_0000;

   localparam logic [13:0] CLAMP_LO   = 14'd1600;
   localparam logic [13:0] CLAMP_HI   = 14'd8400;
   localparam logic [13:0] DRIVE_FULL = 14'd10000;

   // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [6:0] DELAY_MIN = 7'd16;
   localparam logic [6:0] DELAY_MAX = 7'd84;

   typedef struct packed {
      logic [8:0] setpoint;
      logic [9:0] gain_p;
      logic [7:0] gain_i;
      logic [7:0] gain_d;
      logic [8:0] int_limit;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] op;
      logic [8:0] temp;
   } temp_word_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  op;
      logic [8:0]  temp;
      logic [13:0] drive;
   } drive_word_type;

endpackage

[rtl/pidtf_csr.sv]
// Configuration register file: setpoint, PID gains and integral reset limit.
// Depends on pidtf_pkg.
module pidtf_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [9:0]       csr_data,
   output pidtf_pkg::cfg_type cfg
);
   import pidtf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SETPOINT:  cfg_in.setpoint  = csr_data[8:0];
            REG_GAIN_P:    cfg_in.gain_p    = csr_data;
            REG_GAIN_I:    cfg_in.gain_i    = csr_data[7:0];
            REG_GAIN_D:    cfg_in.gain_d    = csr_data[7:0];
            REG_INT_LIMIT: cfg_in.int_limit = csr_data[8:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{setpoint: SETPOINT_RST, gain_p: GAIN_P_RST, gain_i: GAIN_I_RST,
                     gain_d: GAIN_D_RST, int_limit: INT_LIMIT_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

[rtl/pidtf_conv.sv]
// Input register and ADC-to-degrees conversion stage: floor(adc * 500 / 1023).
// Depends on pidtf_pkg.
module pidtf_conv (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_opcode,
   input  logic [9:0]               req_adc_sample,
   input  logic                     dn_ready,
   output pidtf_pkg::temp_word_type dn_word
);
   import pidtf_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   logic [1:0]    s1_op_ff, s1_op_in;
   logic [9:0]    s1_adc_ff, s1_adc_in;
   temp_word_type s2_ff, s2_in;

   logic          ready1, ready2;
   logic [18:0]   scaled;
   logic [8:0]    quot_lo;
   logic [10:0]   remainder;
   logic [8:0]    temp;

   always_comb begin
      ready2 = !s2_ff.valid || dn_ready;
      ready1 = !s1_valid_ff || ready2;

      // adc * 500 = adc * 512 - adc * 8 - adc * 4
      scaled    = {s1_adc_ff, 9'b0}
                  - {6'b0, s1_adc_ff, 3'b0} - {7'b0, s1_adc_ff, 2'b0};
      quot_lo   = scaled[18:10];
      remainder = {1'b0, scaled[9:0]} + {2'b0, quot_lo};
      temp      = (remainder >= ADC_FULL_SCALE) ? quot_lo + 9'd1 : quot_lo;

      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_adc_in   = s1_adc_ff;
      if (ready1) begin
         s1_valid_in = req_valid;
         s1_op_in    = req_opcode;
         s1_adc_in   = req_adc_sample;
      end

      s2_in = s2_ff;
      if (ready2) begin
         s2_in = '{valid: s1_valid_ff, op: s1_op_ff, temp: temp};
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff  <= s1_op_in;
      s1_adc_ff <= s1_adc_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ff       <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_ff       <= s2_in;
      end
   end

   assign req_stall = !ready1;
   assign dn_word   = s2_ff;

endmodule

[rtl/pidtf_pid.sv]
// PID stages: error and gain products, saturating integral, sum, clamp and inversion.
// Holds the integral and last error state. Depends on pidtf_pkg.
module pidtf_pid (
   input  logic                      clock,
   input  logic                      reset,
   input  pidtf_pkg::cfg_type        cfg,
   input  pidtf_pkg::temp_word_type  up_word,
   output logic                      up_ready,
   input  logic                      dn_ready,
   output pidtf_pkg::drive_word_type dn_word
);
   import pidtf_pkg::*;

   logic                s3_valid_ff, s3_valid_in;
   logic [1:0]          s3_op_ff, s3_op_in;
   logic [8:0]          s3_temp_ff, s3_temp_in;
   logic                s3_clr_ff, s3_clr_in;
   logic signed [21:0]  s3_prod_p_ff, s3_prod_p_in;
   logic signed [19:0]  s3_prod_i_ff, s3_prod_i_in;
   logic signed [20:0]  s3_prod_d_ff, s3_prod_d_in;

   logic                s4_valid_ff, s4_valid_in;
   logic [1:0]          s4_op_ff, s4_op_in;
   logic [8:0]          s4_temp_ff, s4_temp_in;
   logic signed [22:0]  s4_pd_ff, s4_pd_in;

   drive_word_type      s5_ff, s5_in;

   logic signed [10:0]  last_error_ff, last_error_in;
   logic signed [31:0]  integral_ff, integral_in;

   logic                ready3, ready4, ready5;
   logic signed [10:0]  setpoint_s, temp_s, limit_s, err;
   logic signed [10:0]  gain_p_s;
   logic signed [8:0]   gain_i_s, gain_d_s;
   logic signed [11:0]  diff;
   logic signed [31:0]  base;
   logic signed [32:0]  sum;
   logic signed [31:0]  integral_sat;
   logic signed [22:0]  pd;
   logic signed [33:0]  v;
   logic [13:0]         v_clamped;

   always_comb begin
      ready5 = !s5_ff.valid || dn_ready;
      ready4 = !s4_valid_ff || ready5;
      ready3 = !s3_valid_ff || ready4;

      setpoint_s = $signed({2'b0, cfg.setpoint});
      temp_s     = $signed({2'b0, up_word.temp});
      limit_s    = $signed({2'b0, cfg.int_limit});
      gain_p_s   = $signed({1'b0, cfg.gain_p});
      gain_i_s   = $signed({1'b0, cfg.gain_i});
      gain_d_s   = $signed({1'b0, cfg.gain_d});
      err        = setpoint_s - temp_s;
      diff       = err - last_error_ff;

      s3_valid_in  = s3_valid_ff;
      s3_op_in     = s3_op_ff;
      s3_temp_in   = s3_temp_ff;
      s3_clr_in    = s3_clr_ff;
      s3_prod_p_in = s3_prod_p_ff;
      s3_prod_i_in = s3_prod_i_ff;
      s3_prod_d_in = s3_prod_d_ff;
      last_error_in = last_error_ff;
      if (ready3) begin
         s3_valid_in  = up_word.valid;
         s3_op_in     = up_word.op;
         s3_temp_in   = up_word.temp;
         s3_clr_in    = err > limit_s;
         s3_prod_p_in = gain_p_s * err;
         s3_prod_i_in = gain_i_s * err;
         s3_prod_d_in = gain_d_s * diff;
         if (up_word.valid && up_word.op == OP_SAMPLE) begin
            last_error_in = err;
         end
      end

      if (s3_clr_ff) begin
         base = '0;
      end else begin
         base = integral_ff;
      end
      sum = base + s3_prod_i_ff;
      if (sum[32] != sum[31]) begin
         integral_sat = sum[32] ? INTEGRAL_MIN : INTEGRAL_MAX;
      end else begin
         integral_sat = sum[31:0];
      end
      pd = s3_prod_p_ff + s3_prod_d_ff;

      s4_valid_in = s4_valid_ff;
      s4_op_in    = s4_op_ff;
      s4_temp_in  = s4_temp_ff;
      s4_pd_in    = s4_pd_ff;
      integral_in = integral_ff;
      if (ready4) begin
         s4_valid_in = s3_valid_ff;
         s4_op_in    = s3_op_ff;
         s4_temp_in  = s3_temp_ff;
         s4_pd_in    = pd;
         if (s3_valid_ff && s3_op_ff == OP_SAMPLE) begin
            integral_in = integral_sat;
         end
      end

      v = s4_pd_ff + integral_ff;
      if (v < $signed(34'(CLAMP_LO))) begin
         v_clamped = CLAMP_LO;
      end else if (v > $signed(34'(CLAMP_HI))) begin
         v_clamped = CLAMP_HI;
      end else begin
         v_clamped = v[13:0];
      end

      s5_in = s5_ff;
      if (ready5) begin
         s5_in = '{valid: s4_valid_ff, op: s4_op_ff, temp: s4_temp_ff,
                   drive: DRIVE_FULL - v_clamped};
      end
   end

   always_ff @(posedge clock) begin
      s3_op_ff     <= s3_op_in;
      s3_temp_ff   <= s3_temp_in;
      s3_clr_ff    <= s3_clr_in;
      s3_prod_p_ff <= s3_prod_p_in;
      s3_prod_i_ff <= s3_prod_i_in;
      s3_prod_d_ff <= s3_prod_d_in;
      s4_op_ff     <= s4_op_in;
      s4_temp_ff   <= s4_temp_in;
      s4_pd_ff     <= s4_pd_in;
      if (reset) begin
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         s5_ff         <= '0;
         last_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         s3_valid_ff   <= s3_valid_in;
         s4_valid_ff   <= s4_valid_in;
         s5_ff         <= s5_in;
         last_error_ff <= last_error_in;
         integral_ff   <= integral_in;
      end
   end

   assign up_ready = ready3;
   assign dn_word  = s5_ff;

endmodule

[rtl/pidtf_fire.sv]
// Firing stage: drive-to-delay conversion, zero-cross arming, tick counting and
// the result register. Depends on pidtf_pkg.
module pidtf_fire (
   input  logic                      clock,
   input  logic                      reset,
   input  pidtf_pkg::drive_word_type up_word,
   output logic                      up_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [8:0]                rsp_temperature,
   output logic [13:0]               rsp_drive_level,
   output logic [6:0]                rsp_fire_delay,
   output logic                      rsp_fire_pulse
);
   import pidtf_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        pulse_ff, pulse_in;
   logic [8:0]  temp_ff, temp_in;
   logic [13:0] drive_ff, drive_in;
   logic [6:0]  delay_ff, delay_in;
   logic [6:0]  tick_ff, tick_in;
   logic        armed_ff, armed_in;

   logic        ready;
   logic [26:0] recip_prod;
   logic [6:0]  delay_new;
   logic [6:0]  tick_next;

   always_comb begin
      ready      = !rsp_valid_ff || !rsp_stall;
      recip_prod = up_word.drive * RECIP_100;
      delay_new  = recip_prod[RECIP_SHIFT+6:RECIP_SHIFT];
      tick_next  = tick_ff + 7'd1;

      rsp_valid_in = rsp_valid_ff;
      pulse_in     = pulse_ff;
      temp_in      = temp_ff;
      drive_in     = drive_ff;
      delay_in     = delay_ff;
      tick_in      = tick_ff;
      armed_in     = armed_ff;
      if (ready) begin
         rsp_valid_in = up_word.valid;
         pulse_in     = 1'b0;
         if (up_word.valid) begin
            case (up_word.op)
               OP_SAMPLE: begin
                  temp_in  = up_word.temp;
                  drive_in = up_word.drive;
                  delay_in = delay_new;
               end
               OP_ZERO_CROSS: begin
                  armed_in = 1'b1;
               end
               OP_TICK: begin
                  if (armed_ff) begin
                     tick_in = tick_next;
                     if (delay_ff != 7'd0 && tick_next == delay_ff) begin
                        pulse_in = 1'b1;
                        tick_in  = 7'd0;
                        armed_in = 1'b0;
                     end
                  end
               end
               default: begin
                  pulse_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pulse_ff     <= 1'b0;
         temp_ff      <= '0;
         drive_ff     <= '0;
         delay_ff     <= '0;
         tick_ff      <= '0;
         armed_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pulse_ff     <= pulse_in;
         temp_ff      <= temp_in;
         drive_ff     <= drive_in;
         delay_ff     <= delay_in;
         tick_ff      <= tick_in;
         armed_ff     <= armed_in;
      end
   end

   assign up_ready        = ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = temp_ff;
   assign rsp_drive_level = drive_ff;
   assign rsp_fire_delay  = delay_ff;
   assign rsp_fire_pulse  = pulse_ff;

endmodule

[rtl/pid_triac_phase_firing.sv]
// Heater controller top level: PID temperature loop driving a triac firing delay.
// Instantiates pidtf_csr, pidtf_conv, pidtf_pid and pidtf_fire; depends on pidtf_pkg.
//
// Request channel (req_): one word per opcode: temperature sample with a 10-bit ADC
// reading, zero crossing, or timer tick. Taken when req_valid is high and req_stall low.
// Response channel (rsp_): exactly one word per request, in order, reporting the last
// temperature, drive level, firing delay and a fire pulse for a tick that fires.
// Config channel (csr_): index/data writes to setpoint, three gains and integral reset
// limit; always ready. Write only while the block is idle; the block does not check it.
// Requests pass through six register stages (input, conversion, products, integral,
// clamp, result). While rsp_stall is low, one word per cycle is taken and delivered,
// with no dependency stall between consecutive samples: the last error and integral are
// each updated in the stage that computes their next value (products, integral).
// When rsp_stall holds a result, the stages behind it keep filling their empty
// slots; req_stall rises only once every stage holds a word.
// Synchronous reset empties the pipeline, restores the register reset values,
// clears the integral, drive and delay and disarms the firing counter.
module pid_triac_phase_firing (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [9:0]  req_adc_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_temperature,
   output logic [13:0] rsp_drive_level,
   output logic [6:0]  rsp_fire_delay,
   output logic        rsp_fire_pulse,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data
);
   import pidtf_pkg::*;

   cfg_type        cfg;
   temp_word_type  temp_word;
   drive_word_type drive_word;
   logic           pid_ready;
   logic           fire_ready;

   pidtf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pidtf_conv u_conv (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_adc_sample (req_adc_sample),
      .dn_ready       (pid_ready),
      .dn_word        (temp_word)
   );

   pidtf_pid u_pid (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_word  (temp_word),
      .up_ready (pid_ready),
      .dn_ready (fire_ready),
      .dn_word  (drive_word)
   );

   pidtf_fire u_fire (
      .clock           (clock),
      .reset           (reset),
      .up_word         (drive_word),
      .up_ready        (fire_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_temperature (rsp_temperature),
      .rsp_drive_level (rsp_drive_level),
      .rsp_fire_delay  (rsp_fire_delay),
      .rsp_fire_pulse  (rsp_fire_pulse)
   );

endmodule

[rtl/pidtf_checker.sv]
// Port-level checks for pid_triac_phase_firing, bound to the top level.
// Depends on pidtf_pkg.
module pidtf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [8:0]  rsp_temperature,
   input logic [13:0] rsp_drive_level,
   input logic [6:0]  rsp_fire_delay,
   input logic        rsp_fire_pulse
);
   import pidtf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temperature)
         && $stable(rsp_drive_level) && $stable(rsp_fire_delay) && $stable(rsp_fire_pulse))
      else $error("stalled response word changed");

   a_pulse_needs_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fire_pulse |-> rsp_fire_delay != 7'd0)
      else $error("fire pulse with zero delay");

   a_drive_delay_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_drive_level == 14'd0) == (rsp_fire_delay == 7'd0)))
      else $error("drive level and delay disagree on first sample");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_level != 14'd0 |->
         rsp_drive_level >= CLAMP_LO && rsp_drive_level <= CLAMP_HI
         && rsp_fire_delay >= DELAY_MIN && rsp_fire_delay <= DELAY_MAX)
      else $error("drive level or delay out of range");

endmodule

bind pid_triac_phase_firing pidtf_checker u_pidtf_checker (.*);

[test/tb_pid_triac_phase_firing.sv]
// Testbench for pid_triac_phase_firing: a directed table and random traffic, each word
// checked field by field against its table row or a cycle-free model of the PID loop
// and firing counter. Depends on pidtf_pkg and the pid_triac_phase_firing RTL.
module tb_pid_triac_phase_firing;
   import pidtf_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [8:0]  temp;
      logic [13:0] drive;
      logic [6:0]  delay;
      logic        pulse;
   } report_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [9:0]  adc;
      logic [7:0]  count;
      logic        typed;
      logic [8:0]  temp;
      logic [13:0] drive;
      logic [6:0]  delay;
      logic        pulse;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [9:0]  req_adc_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [8:0]  rsp_temperature;
   logic [13:0] rsp_drive_level;
   logic [6:0]  rsp_fire_delay;
   logic        rsp_fire_pulse;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [9:0]  csr_data;

   // controller settings as the model sees them
   int set_temp;
   int kp;
   int ki;
   int kd;
   int clear_band;

   // controller state
   longint     integ_acc;
   int         prev_err;
   logic [8:0] temp_now;
   logic [13:0] drive_now;
   logic [6:0] delay_now;
   logic [6:0] tick_now;
   bit         gate_armed;
   bit         gate_fired;

   report_type   pending_reports[$];
   report_type   want;
   stim_row_type opening_rows[14];
   int           error_count;
   bit           quiet;
   bit           long_hold_req;

   pid_triac_phase_firing dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_adc_sample(req_adc_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_temperature(rsp_temperature),
      .rsp_drive_level(rsp_drive_level),
      .rsp_fire_delay(rsp_fire_delay),
      .rsp_fire_pulse(rsp_fire_pulse),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_pid_triac_phase_firing failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      error_count++;
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, exp_val, $realtime);
   endtask

   function automatic report_type advance_controller(input logic [1:0] op,
                                                     input logic [9:0] adc);
      report_type rep;
      int         err;
      longint     v;
      gate_fired = 1'b0;
      if (op == OP_SAMPLE) begin
         temp_now = 9'((int'(adc) * 500) / 1023);
         err = set_temp - int'(temp_now);
         if (err > clear_band)
            integ_acc = 0;
         integ_acc = integ_acc + longint'(ki) * longint'(err);
         if (integ_acc > longint'(INTEGRAL_MAX))
            integ_acc = longint'(INTEGRAL_MAX);
         if (integ_acc < longint'(INTEGRAL_MIN))
            integ_acc = longint'(INTEGRAL_MIN);
         v = longint'(kp) * err + integ_acc + longint'(kd) * (err - prev_err);
         prev_err = err;
         if (v < 1600)
            v = 1600;
         if (v > 8400)
            v = 8400;
         drive_now = 14'(10000 - v);
         delay_now = 7'(drive_now / 100);
      end else if (op == OP_ZERO_CROSS) begin
         gate_armed = 1'b1;
      end else if (op == OP_TICK) begin
         if (gate_armed) begin
            tick_now = tick_now + 7'd1;
            if (delay_now != 7'd0 && tick_now == delay_now) begin
               gate_fired = 1'b1;
               tick_now = 7'd0;
               gate_armed = 1'b0;
            end
         end
      end
      rep.temp = temp_now;
      rep.drive = drive_now;
      rep.delay = delay_now;
      rep.pulse = gate_fired;
      return rep;
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [9:0] adc, input bit typed,
                            input report_type typed_want);
      report_type rep;
      rep = advance_controller(op, adc);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_adc_sample <= adc;
      do @(posedge clock); while (req_stall);
      pending_reports.push_back(typed ? typed_want : rep);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SETPOINT:  set_temp = int'(data[8:0]);
         REG_GAIN_P:    kp = int'(data[9:0]);
         REG_GAIN_I:    ki = int'(data[7:0]);
         REG_GAIN_D:    kd = int'(data[7:0]);
         REG_INT_LIMIT: clear_band = int'(data[8:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [9:0] sp, input logic [9:0] p, input logic [9:0] i,
                                input logic [9:0] d, input logic [9:0] lim);
      write_reg(REG_SETPOINT, sp);
      write_reg(REG_GAIN_P, p);
      write_reg(REG_GAIN_I, i);
      write_reg(REG_GAIN_D, d);
      write_reg(REG_INT_LIMIT, lim);
   endtask

   task automatic load_random_settings();
      load_settings({1'($urandom_range(0, 1)), 9'($urandom_range(0, 500))},
                    10'($urandom), 10'($urandom), 10'($urandom),
                    {1'($urandom_range(0, 1)), 9'($urandom_range(0, 500))});
   endtask

   // drop valid and let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_traffic(input int n_items);
      int sent;
      int pick;
      int guard;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            if ($urandom_range(0, 1) == 1) begin
               send_word(OP_SAMPLE, 10'($urandom), 1'b0, '0);
               sent++;
            end
            send_word(OP_ZERO_CROSS, 10'($urandom), 1'b0, '0);
            sent++;
            guard = 0;
            do begin
               if ($urandom_range(0, 11) == 0)
                  send_word(OP_SAMPLE, 10'($urandom), 1'b0, '0);
               else
                  send_word(OP_TICK, 10'($urandom), 1'b0, '0);
               sent++;
               guard++;
            end while (!gate_fired && guard < 220);
         end else if (pick == 7) begin
            send_word(2'($urandom), 10'($urandom), 1'b0, '0);
            sent++;
         end else begin
            send_word(OP_ZERO_CROSS, 10'($urandom), 1'b0, '0);
            sent++;
            repeat ($urandom_range(1, 5)) begin
               send_word(OP_TICK, 10'($urandom), 1'b0, '0);
               sent++;
            end
            send_word(OP_SAMPLE, 10'($urandom), 1'b0, '0);
            sent++;
         end
      end
   endtask

   // push the integral toward one rail with a run of one-sided samples
   task automatic soak_integral(input int adc_lo, input int adc_hi, input int n_items);
      repeat (n_items) send_word(OP_SAMPLE, 10'($urandom_range(adc_hi, adc_lo)), 1'b0, '0);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (40) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("word with nothing pending, temperature", rsp_temperature, -1);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_temperature !== want.temp)
               report_mismatch("temperature", rsp_temperature, want.temp);
            if (rsp_drive_level !== want.drive)
               report_mismatch("drive_level", rsp_drive_level, want.drive);
            if (rsp_fire_delay !== want.delay)
               report_mismatch("fire_delay", rsp_fire_delay, want.delay);
            if (rsp_fire_pulse !== want.pulse)
               report_mismatch("fire_pulse", rsp_fire_pulse, want.pulse);
         end
      end
   end

   initial begin
      report_type typed_want;
      int         ph;
      error_count = 0;
      quiet = 1'b0;
      long_hold_req = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_SAMPLE;
      req_adc_sample = 10'd0;
      csr_valid = 1'b0;
      csr_index = REG_SETPOINT;
      csr_data = 10'd0;

      set_temp = int'(SETPOINT_RST);
      kp = int'(GAIN_P_RST);
      ki = int'(GAIN_I_RST);
      kd = int'(GAIN_D_RST);
      clear_band = int'(INT_LIMIT_RST);
      integ_acc = 0;
      prev_err = 0;
      temp_now = '0;
      drive_now = '0;
      delay_now = '0;
      tick_now = '0;
      gate_armed = 1'b0;
      gate_fired = 1'b0;

      opening_rows = '{
         '{OP_TICK,       10'd0,    8'd1,  1'b1, 9'd0,   14'd0,    7'd0,  1'b0},
         '{OP_ZERO_CROSS, 10'd0,    8'd1,  1'b1, 9'd0,   14'd0,    7'd0,  1'b0},
         '{OP_TICK,       10'd0,    8'd2,  1'b1, 9'd0,   14'd0,    7'd0,  1'b0},
         '{OP_UNUSED,     10'h3FF,  8'd1,  1'b1, 9'd0,   14'd0,    7'd0,  1'b0},
         '{OP_SAMPLE,     10'd1023, 8'd1,  1'b1, 9'd500, 14'd8400, 7'd84, 1'b0},
         '{OP_ZERO_CROSS, 10'd0,    8'd1,  1'b1, 9'd500, 14'd8400, 7'd84, 1'b0},
         '{OP_TICK,       10'd0,    8'd1,  1'b1, 9'd500, 14'd8400, 7'd84, 1'b0},
         '{OP_SAMPLE,     10'd0,    8'd1,  1'b1, 9'd0,   14'd1600, 7'd16, 1'b0},
         '{OP_TICK,       10'd0,    8'd12, 1'b0, 9'd0,   14'd0,    7'd0,  1'b0},
         '{OP_TICK,       10'd0,    8'd1,  1'b1, 9'd0,   14'd1600, 7'd16, 1'b1},
         '{OP_TICK,       10'd0,    8'd1,  1'b1, 9'd0,   14'd1600, 7'd16, 1'b0},
         '{OP_SAMPLE,     10'h2AA,  8'd1,  1'b0, 9'd0,   14'd0,    7'd0,  1'b0},
         '{OP_SAMPLE,     10'h155,  8'd1,  1'b0, 9'd0,   14'd0,    7'd0,  1'b0},
         '{OP_UNUSED,     10'd0,    8'd1,  1'b0, 9'd0,   14'd0,    7'd0,  1'b0}
      };

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (opening_rows[r]) begin
         typed_want.temp = opening_rows[r].temp;
         typed_want.drive = opening_rows[r].drive;
         typed_want.delay = opening_rows[r].delay;
         typed_want.pulse = opening_rows[r].pulse;
         repeat (opening_rows[r].count)
            send_word(opening_rows[r].op, opening_rows[r].adc, opening_rows[r].typed,
                      typed_want);
      end

      settle();
      load_settings(10'd500, 10'd1023, 10'd255, 10'd255, 10'd500);
      long_hold_req = 1'b1;
      run_traffic(40);

      settle();
      load_settings(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      run_traffic(30);

      settle();
      load_settings(10'd500, 10'd1023, 10'd255, 10'd255, 10'd500);
      soak_integral(0, 2, 15);
      settle();
      write_reg(REG_INT_LIMIT, 10'd0);
      send_word(OP_SAMPLE, 10'd0, 1'b0, '0);
      settle();
      write_reg(REG_SETPOINT, 10'd0);
      write_reg(REG_INT_LIMIT, 10'd500);
      soak_integral(1021, 1023, 15);

      for (ph = 0; ph < 3; ph++) begin
         settle();
         load_random_settings();
         run_traffic(40);
      end

      settle();
      quiet = 1'b1;
      load_random_settings();
      run_traffic(30);

      settle();
      if (error_count == 0)
         $display("tb_pid_triac_phase_firing passed");
      else
         $display("tb_pid_triac_phase_firing failed");
      $finish;
   end

endmodule
